/* hw/rtl/kcpd_pkg.sv */
package kcpd_pkg;

   localparam logic [7:0] HDR_MIN = 8'd246;
   localparam logic [3:0] KIND_TIME = 4'd6;
   localparam int unsigned TIME_BYTES = 6;
   localparam logic [7:0] MONTH_MAX = 8'd12;
   localparam logic [3:0] NIBBLE_MASK = 4'hf;

   typedef logic [TIME_BYTES-1:0][7:0] time_bytes_type;

   typedef struct packed {
      logic valid;
      time_bytes_type bytes;
   } time_push_type;

   function automatic logic [2:0] body_len(input logic [3:0] kind);
      logic [2:0] len;
      case (kind)
         4'd0: len = 3'd7;
         4'd1: len = 3'd5;
         4'd2: len = 3'd2;
         4'd3: len = 3'd2;
         4'd4: len = 3'd2;
         4'd5: len = 3'd2;
         4'd6: len = 3'd6;
         4'd7: len = 3'd2;
         4'd8: len = 3'd1;
         4'd9: len = 3'd1;
         default: len = 3'd7;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] bcd_value(input logic [7:0] b);
      logic [3:0] hi;
      logic [3:0] lo;
      hi = b[7:4] & NIBBLE_MASK;
      lo = b[3:0] & NIBBLE_MASK;
      return {1'b0, hi, 3'b000} + {3'b000, hi, 1'b0} + {4'h0, lo};
   endfunction

endpackage

/* hw/rtl/keyboard_clock_packet_decoder.sv */
// Channel   Direction  Payload
// req_      in         tdata[7:0] rx_byte
// rsp_      out        tdata: year, month, day, hour, minute, second, clock_unset, month_valid
//
// One byte request is taken every cycle while the two-entry result queue has room.
// A time packet's result is written into the queue with its last byte, then taken into the output register.
// Reset is synchronous and returns the parser to idle and empties the queue.
// A stalled result side holds the output register; bytes keep flowing until the queue fills.
module keyboard_clock_packet_decoder (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [7:0] req_tdata,   // [7:0] rx_byte
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [55:0] rsp_tdata   // [7:0] year, [15:8] month, [23:16] day, [31:24] hour,
                                   // [39:32] minute, [47:40] second, [48] clock_unset,
                                   // [49] month_valid, [55:50] zero
);

   kcpd_pkg::time_push_type push;
   kcpd_pkg::time_bytes_type q_bytes;
   logic q_full;
   logic q_valid;
   logic pop;

   assign req_tready = !q_full;

   kcpd_front u_front (
      .clock(clock),
      .reset(reset),
      .accept(req_tvalid && req_tready),
      .rx_byte(req_tdata),
      .push(push)
   );

   kcpd_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .pop(pop),
      .full(q_full),
      .out_valid(q_valid),
      .out_bytes(q_bytes)
   );

   kcpd_back u_back (
      .clock(clock),
      .reset(reset),
      .in_valid(q_valid),
      .in_bytes(q_bytes),
      .pop(pop),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_data(rsp_tdata)
   );

endmodule

/* hw/rtl/kcpd_front.sv */
module kcpd_front (
   input  logic clock,
   input  logic reset,
   input  logic accept,
   input  logic [7:0] rx_byte,
   output kcpd_pkg::time_push_type push
);

   logic in_packet_ff, in_packet_in;
   logic [3:0] kind_ff, kind_in;
   logic [2:0] left_ff, left_in;
   logic [2:0] slot_ff, slot_in;
   logic [7:0] tb_ff [5];

   always_comb begin
      in_packet_in = in_packet_ff;
      kind_in = kind_ff;
      left_in = left_ff;
      slot_in = slot_ff;
      push.valid = 1'b0;
      push.bytes = {rx_byte, tb_ff[4], tb_ff[3], tb_ff[2], tb_ff[1], tb_ff[0]};
      if (accept) begin
         if (!in_packet_ff) begin
            if (rx_byte >= kcpd_pkg::HDR_MIN) begin
               kind_in = 4'(rx_byte - kcpd_pkg::HDR_MIN);
               left_in = kcpd_pkg::body_len(kind_in);
               slot_in = 3'd0;
               in_packet_in = 1'b1;
            end
         end else begin
            slot_in = slot_ff + 3'd1;
            left_in = left_ff - 3'd1;
            if (left_in == 3'd0) begin
               in_packet_in = 1'b0;
               push.valid = (kind_ff == kcpd_pkg::KIND_TIME);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_packet_ff <= 1'b0;
         kind_ff <= 4'd0;
         left_ff <= 3'd0;
         slot_ff <= 3'd0;
      end else begin
         in_packet_ff <= in_packet_in;
         kind_ff <= kind_in;
         left_ff <= left_in;
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && in_packet_ff && slot_ff < 3'd5) begin
         tb_ff[slot_ff] <= rx_byte;
      end
   end

endmodule

/* hw/rtl/kcpd_queue.sv */
module kcpd_queue (
   input  logic clock,
   input  logic reset,
   input  kcpd_pkg::time_push_type push,
   input  logic pop,
   output logic full,
   output logic out_valid,
   output kcpd_pkg::time_bytes_type out_bytes
);

   logic [1:0] count_ff, count_in;
   logic wr_ff, rd_ff;
   kcpd_pkg::time_bytes_type mem_ff [2];

   assign full = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_bytes = mem_ff[rd_ff];

   always_comb begin
      count_in = count_ff;
      if (push.valid && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push.valid) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push.valid) begin
            wr_ff <= ~wr_ff;
         end
         if (pop) begin
            rd_ff <= ~rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ff] <= push.bytes;
      end
   end

endmodule

/* hw/rtl/kcpd_back.sv */
module kcpd_back (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  kcpd_pkg::time_bytes_type in_bytes,
   output logic pop,
   output logic out_valid,
   input  logic out_ready,
   output logic [55:0] out_data
);

   logic valid_ff;
   logic [55:0] data_ff, data_in;
   logic [7:0] month;
   logic unset;

   assign pop = in_valid && (!valid_ff || out_ready);
   assign month = kcpd_pkg::bcd_value(in_bytes[1]);
   assign unset = (in_bytes == '0);
   assign out_valid = valid_ff;
   assign out_data = data_ff;

   always_comb begin
      data_in[7:0] = kcpd_pkg::bcd_value(in_bytes[0]);
      data_in[15:8] = month;
      data_in[23:16] = kcpd_pkg::bcd_value(in_bytes[2]);
      data_in[31:24] = kcpd_pkg::bcd_value(in_bytes[3]);
      data_in[39:32] = kcpd_pkg::bcd_value(in_bytes[4]);
      data_in[47:40] = kcpd_pkg::bcd_value(in_bytes[5]);
      data_in[48] = unset;
      data_in[49] = month inside {[8'd1 : kcpd_pkg::MONTH_MAX]};
      data_in[55:50] = 6'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= data_in;
      end
   end

endmodule

/* bench/tb_top.sv */
typedef struct packed {
   logic [5:0] pad;
   logic       month_valid;
   logic       clock_unset;
   logic [7:0] second;
   logic [7:0] minute;
   logic [7:0] hour;
   logic [7:0] day;
   logic [7:0] month;
   logic [7:0] year;
} clock_reading_type;

class time_packet_tracker;
   logic [2:0] body_length [10];
   bit busy;
   logic [3:0] kind;
   logic [2:0] remaining;
   logic [2:0] slot;
   logic [7:0] stash [6];
   clock_reading_type awaited_readings [$];
   int failures;

   function new();
      body_length = '{3'd7, 3'd5, 3'd2, 3'd2, 3'd2, 3'd2, 3'd6, 3'd2, 3'd1, 3'd1};
      busy = 0;
      kind = '0;
      remaining = '0;
      slot = '0;
      failures = 0;
   endfunction

   function logic [7:0] decimal_of(input logic [7:0] b);
      logic [7:0] tens;
      tens = {4'h0, b[7:4]};
      return tens * 8'd10 + {4'h0, b[3:0]};
   endfunction

   function void take_byte(input logic [7:0] b);
      clock_reading_type r;
      if (!busy) begin
         if (b >= kcpd_pkg::HDR_MIN) begin
            kind = 4'(b - kcpd_pkg::HDR_MIN);
            remaining = body_length[kind];
            slot = '0;
            busy = 1;
         end
         return;
      end
      if (slot < 3'd6) begin
         stash[slot] = b;
      end
      slot = slot + 3'd1;
      remaining = remaining - 3'd1;
      if (remaining != 3'd0) begin
         return;
      end
      busy = 0;
      if (kind != kcpd_pkg::KIND_TIME) begin
         return;
      end
      r = '0;
      r.year = decimal_of(stash[0]);
      r.month = decimal_of(stash[1]);
      r.day = decimal_of(stash[2]);
      r.hour = decimal_of(stash[3]);
      r.minute = decimal_of(stash[4]);
      r.second = decimal_of(stash[5]);
      r.clock_unset = (stash[0] == 0 && stash[1] == 0 && stash[2] == 0 &&
                       stash[3] == 0 && stash[4] == 0 && stash[5] == 0);
      r.month_valid = (r.month >= 8'd1 && r.month <= kcpd_pkg::MONTH_MAX);
      awaited_readings.push_back(r);
   endfunction

   function void compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   function void check_reading(input logic [55:0] data);
      clock_reading_type got;
      clock_reading_type want;
      got = data;
      if (awaited_readings.size() == 0) begin
         $error("unexpected clock reading %h", data);
         failures++;
         return;
      end
      want = awaited_readings.pop_front();
      compare_field("year", want.year, got.year);
      compare_field("month", want.month, got.month);
      compare_field("day", want.day, got.day);
      compare_field("hour", want.hour, got.hour);
      compare_field("minute", want.minute, got.minute);
      compare_field("second", want.second, got.second);
      compare_field("clock_unset", want.clock_unset, got.clock_unset);
      compare_field("month_valid", want.month_valid, got.month_valid);
      compare_field("pad", want.pad, got.pad);
   endfunction
endclass

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [7:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [55:0] rsp_tdata;

   time_packet_tracker tracker = new;
   bit sender_calm = 0;
   int packet_bytes_sent = 0;

   keyboard_clock_packet_decoder DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   task automatic send_byte(input logic [7:0] b);
      while (!sender_calm && $urandom_range(0, 99) < 16) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      tracker.take_byte(b);
   endtask

   task automatic send_time_packet(input logic [7:0] body [6]);
      send_byte(kcpd_pkg::HDR_MIN + 8'(kcpd_pkg::KIND_TIME));
      foreach (body[i]) begin
         send_byte(body[i]);
      end
      packet_bytes_sent += 7;
   endtask

   task automatic send_other_packet(input logic [3:0] kind);
      send_byte(kcpd_pkg::HDR_MIN + 8'(kind));
      for (int i = 0; i < tracker.body_length[kind]; i++) begin
         send_byte($urandom_range(0, 3) == 0
                   ? 8'($urandom_range(kcpd_pkg::HDR_MIN, 255))
                   : 8'($urandom_range(0, 255)));
      end
      packet_bytes_sent += 1 + tracker.body_length[kind];
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         tracker.check_reading(rsp_tdata);
      end
   end

   initial begin
      int cycle;
      cycle = 0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            cycle++;
         end
         if (cycle >= 300 && cycle < 600) begin
            rsp_tready <= 1'b0;
         end else if (cycle >= 800 && cycle < 1000) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= 16);
         end
      end
   end

   initial begin
      logic [7:0] body [6];
      logic [3:0] kind;
      logic [3:0] tens;
      int pick;
      int month_num;
      int waited;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Bytes below the header range are dropped while idle.
      send_byte(8'h00);
      send_byte(kcpd_pkg::HDR_MIN - 8'd1);
      body = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      send_time_packet(body);
      body = '{8'h99, 8'h12, 8'hff, 8'hf6, 8'h59, 8'hab};
      send_time_packet(body);
      // A body byte in the header range is still body.
      send_byte(8'hff);
      send_byte(kcpd_pkg::HDR_MIN + 8'(kcpd_pkg::KIND_TIME));
      body = '{8'h00, 8'h13, 8'h31, 8'h23, 8'h00, 8'h01};
      send_time_packet(body);

      while (packet_bytes_sent < 750) begin
         sender_calm = (packet_bytes_sent > 300 && packet_bytes_sent < 450);
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            foreach (body[i]) begin
               body[i] = 8'($urandom_range(0, 255));
            end
            if ($urandom_range(0, 1) == 1) begin
               month_num = $urandom_range(1, 12);
               tens = 4'(month_num / 10);
               body[1] = {tens, 4'(month_num % 10)};
            end
            if ($urandom_range(0, 99) < 5) begin
               body = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
            end
            send_time_packet(body);
         end else if (pick < 90) begin
            kind = 4'($urandom_range(0, 9));
            if (kind == kcpd_pkg::KIND_TIME) begin
               kind = 4'd0;
            end
            send_other_packet(kind);
         end else begin
            send_byte(8'($urandom_range(0, kcpd_pkg::HDR_MIN - 1)));
         end
      end
      sender_calm = 0;
      req_tvalid <= 1'b0;

      waited = 0;
      while (tracker.awaited_readings.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (tracker.awaited_readings.size() != 0) begin
         $error("%0d clock readings never arrived", tracker.awaited_readings.size());
         tracker.failures++;
      end
      if (tracker.failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/kcpd_pkg.sv
hw/rtl/kcpd_front.sv
hw/rtl/kcpd_queue.sv
hw/rtl/kcpd_back.sv
hw/rtl/keyboard_clock_packet_decoder.sv
bench/tb_top.sv
